FILE: rtl/timer_deadline_min_heap_assert.svh
// assertion macros for the timer deadline heap
`ifndef TIMER_DEADLINE_MIN_HEAP_ASSERT_SVH
`define TIMER_DEADLINE_MIN_HEAP_ASSERT_SVH

`ifndef SYNTH
// plain property checked on clk_i, off during reset
`define TDMH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// implication checked on clk_i, off during reset
`define TDMH_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define TDMH_ASSERT(lbl, prop, msg)
`define TDMH_ASSERT_IMPL(lbl, ante, cons, msg)
`endif

`endif

FILE: rtl/tdmh_pkg.sv
// types and codes shared by the timer deadline heap
`default_nettype none

package tdmh_pkg;

  localparam int unsigned DL_W      = 32;
  localparam int unsigned HND_W     = 16;
  localparam int unsigned CNT_OUT_W = 5;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } tdmh_op_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } tdmh_status_e;

  typedef struct packed {
    logic [DL_W-1:0]  deadline;
    logic [HND_W-1:0] handle;
  } tdmh_entry_t;

  typedef struct packed {
    tdmh_op_e         opcode;
    logic [DL_W-1:0]  now_ms;
    logic [DL_W-1:0]  interval_ms;
    logic [HND_W-1:0] handle;
  } tdmh_in_t;

  typedef struct packed {
    tdmh_status_e         status;
    logic [HND_W-1:0]     popped_handle;
    logic [DL_W-1:0]      popped_deadline;
    logic                 next_valid;
    logic [DL_W-1:0]      next_deadline;
    logic [DL_W-1:0]      next_delay_ms;
    logic [CNT_OUT_W-1:0] entry_count;
  } tdmh_out_t;

endpackage

`default_nettype wire

FILE: rtl/timer_deadline_min_heap.sv
// top level of the timer deadline heap
`default_nettype none

// Timer deadline queue: a binary min-heap of up to POOL_DEPTH entries keyed by
// a 32-bit absolute deadline, held in one entry ram (deadline and handle).
// An item is taken when start is high and busy is low; busy stays high until
// the result is out. A push stores now_ms + interval_ms (mod 2^32) and climbs
// toward the root; a pop hands back the root, moves the last entry to the
// root and sinks it. Every item gives exactly one result, shown on result_o
// for the single cycle that done_o is high; the receiver cannot stall it, so
// it must take it then. A new item may be started in that same cycle.
// Timing is set by the single read port of the entry ram. A push reads one
// parent per level it climbs; a pop reads the root and the last entry, then
// the left and right child per level it sinks; each item then reads the root
// for the next deadline, unless the heap is empty.

`include "timer_deadline_min_heap_assert.svh"

module timer_deadline_min_heap
  import tdmh_pkg::*;
#(
  parameter int unsigned POOL_DEPTH = 16
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start,
  input  wire tdmh_in_t  item_i,
  output logic           busy,
  output logic           done_o,
  output tdmh_out_t      result_o
);

  // address, fill count and child index widths
  localparam int unsigned AW = $clog2(POOL_DEPTH);
  localparam int unsigned CW = $clog2(POOL_DEPTH + 1);
  localparam int unsigned IW = AW + 2;

  // sequencer states
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_UP       = 4'd1;   // read parent of hole
  localparam logic [3:0] S_UP_CMP   = 4'd2;   // compare parent, move or settle
  localparam logic [3:0] S_POP_ROOT = 4'd3;   // root data back, read last
  localparam logic [3:0] S_POP_LAST = 4'd4;   // last entry back
  localparam logic [3:0] S_DN_L     = 4'd5;   // read left child
  localparam logic [3:0] S_DN_R     = 4'd6;   // left back, read right child
  localparam logic [3:0] S_DN_CMP   = 4'd7;   // pick smallest, move or settle
  localparam logic [3:0] S_ROOT     = 4'd8;   // read root for next deadline
  localparam logic [3:0] S_ROOT_W   = 4'd9;   // root back, build result

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          done_q, done_d;
  logic          did_pop_q, did_pop_d;
  tdmh_status_e  status_q, status_d;

  // payload: entry being placed, left child, popped root, hole position
  tdmh_entry_t   mov_q, mov_d;
  tdmh_entry_t   lft_q, lft_d;
  tdmh_entry_t   popped_q, popped_d;
  logic [AW-1:0] pos_q, pos_d;
  tdmh_out_t     res_q, res_d;

  // entry ram port
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  tdmh_entry_t   ram_wdata;
  logic [AW-1:0] ram_raddr;
  tdmh_entry_t   ram_rdata;

  tdmh_ram #(
    .WIDTH ($bits(tdmh_entry_t)),
    .DEPTH (POOL_DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // heap index arithmetic around the hole
  logic [AW-1:0] pos_m1, parent;
  logic [CW-1:0] cnt_m1;
  logic [IW-1:0] l_idx, r_idx, cnt_ext;
  logic          l_ok, r_ok;
  logic          take_l, take_r;
  tdmh_entry_t   best_lm;

  assign pos_m1  = pos_q - 1'b1;
  assign parent  = pos_m1 >> 1;
  assign cnt_m1  = cnt_q - 1'b1;
  assign l_idx   = {1'b0, pos_q, 1'b1};
  assign r_idx   = l_idx + 1'b1;
  assign cnt_ext = IW'(cnt_q);
  assign l_ok    = l_idx < cnt_ext;
  assign r_ok    = r_idx < cnt_ext;

  // sift down choice: strictly smaller child wins, left wins a tie between children
  assign take_l  = lft_q.deadline < mov_q.deadline;
  assign best_lm = take_l ? lft_q : mov_q;
  assign take_r  = r_ok && (ram_rdata.deadline < best_lm.deadline);

  // result built from the fill count and the root just read
  tdmh_out_t res_built;
  logic      nxt_valid;

  assign nxt_valid = cnt_q != '0;

  always_comb begin
    res_built                 = '0;
    res_built.status          = status_q;
    res_built.popped_handle   = did_pop_q ? popped_q.handle : '0;
    res_built.popped_deadline = did_pop_q ? popped_q.deadline : '0;
    res_built.next_valid      = nxt_valid;
    res_built.next_deadline   = nxt_valid ? ram_rdata.deadline : '0;
    res_built.next_delay_ms   = (nxt_valid && did_pop_q) ?
                                ram_rdata.deadline - popped_q.deadline : '0;
    res_built.entry_count     = CNT_OUT_W'(cnt_q);
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    done_d    = 1'b0;
    did_pop_d = did_pop_q;
    status_d  = status_q;
    mov_d     = mov_q;
    lft_d     = lft_q;
    popped_d  = popped_q;
    pos_d     = pos_q;
    res_d     = res_q;
    ram_we    = 1'b0;
    ram_waddr = pos_q;
    ram_wdata = mov_q;
    ram_raddr = '0;

    unique case (state_q)
      S_IDLE: begin
        // root read goes out here for a pop
        if (start) begin
          did_pop_d      = 1'b0;
          status_d       = STATUS_OK;
          mov_d.deadline = item_i.now_ms + item_i.interval_ms;
          mov_d.handle   = item_i.handle;
          if (item_i.opcode == OP_PUSH) begin
            if (cnt_q == CW'(POOL_DEPTH)) begin
              status_d = STATUS_FULL;
              state_d  = S_ROOT;
            end else begin
              pos_d   = cnt_q[AW-1:0];
              cnt_d   = cnt_q + 1'b1;
              state_d = S_UP;
            end
          end else begin
            if (cnt_q == '0) begin
              status_d = STATUS_EMPTY;
              state_d  = S_ROOT;
            end else begin
              state_d = S_POP_ROOT;
            end
          end
        end
      end
      S_UP: begin
        if (pos_q == '0) begin
          ram_we  = 1'b1;
          state_d = S_ROOT;
        end else begin
          ram_raddr = parent;
          state_d   = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        ram_we = 1'b1;
        if (ram_rdata.deadline > mov_q.deadline) begin
          // parent moves down into the hole
          ram_wdata = ram_rdata;
          pos_d     = parent;
          state_d   = S_UP;
        end else begin
          state_d = S_ROOT;
        end
      end
      S_POP_ROOT: begin
        popped_d  = ram_rdata;
        did_pop_d = 1'b1;
        ram_raddr = cnt_m1[AW-1:0];
        cnt_d     = cnt_m1;
        state_d   = S_POP_LAST;
      end
      S_POP_LAST: begin
        mov_d = ram_rdata;
        pos_d = '0;
        if (cnt_q == '0) begin
          state_d = S_ROOT;
        end else begin
          state_d = S_DN_L;
        end
      end
      S_DN_L: begin
        if (l_ok) begin
          ram_raddr = l_idx[AW-1:0];
          state_d   = S_DN_R;
        end else begin
          ram_we  = 1'b1;
          state_d = S_ROOT;
        end
      end
      S_DN_R: begin
        lft_d = ram_rdata;
        if (r_ok) begin
          ram_raddr = r_idx[AW-1:0];
        end
        state_d = S_DN_CMP;
      end
      S_DN_CMP: begin
        ram_we = 1'b1;
        if (take_r) begin
          ram_wdata = ram_rdata;
          pos_d     = r_idx[AW-1:0];
          state_d   = S_DN_L;
        end else if (take_l) begin
          ram_wdata = lft_q;
          pos_d     = l_idx[AW-1:0];
          state_d   = S_DN_L;
        end else begin
          state_d = S_ROOT;
        end
      end
      S_ROOT: begin
        // root read is issued by default address zero
        if (cnt_q != '0) begin
          state_d = S_ROOT_W;
        end else begin
          res_d   = res_built;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_ROOT_W: begin
        res_d   = res_built;
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      done_q    <= 1'b0;
      did_pop_q <= 1'b0;
      status_q  <= STATUS_OK;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      done_q    <= done_d;
      did_pop_q <= did_pop_d;
      status_q  <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mov_q    <= mov_d;
    lft_q    <= lft_d;
    popped_q <= popped_d;
    pos_q    <= pos_d;
    res_q    <= res_d;
  end

  assign busy     = state_q != S_IDLE;
  assign done_o   = done_q;
  assign result_o = res_q;

  // fill count never passes the pool size
  `TDMH_ASSERT(a_cnt_bound, cnt_q <= CW'(POOL_DEPTH), "fill count above pool depth")
  // every write lands inside the filled part of the heap
  `TDMH_ASSERT_IMPL(a_wr_in_fill, ram_we, IW'(ram_waddr) < cnt_ext, "write beyond fill")
  // a result comes out exactly when an operation ends
  `TDMH_ASSERT(a_done_ends_op, done_o == $fell(busy), "result strobe not at end of op")
  // next_valid follows the fill count that stays held while idle
  `TDMH_ASSERT_IMPL(a_next_valid, done_o, result_o.next_valid == (cnt_q != '0),
    "next_valid disagrees with fill count")

endmodule

`default_nettype wire

FILE: rtl/tdmh_ram.sv
// generic single-write single-read ram with registered read
`default_nettype none

module tdmh_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire
